>>> sv/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg : shared types and constants for the down-counting timer
// Holds the counter width, register offsets, control bit positions, the item
// and result structs, and helpers that move values between bus and counter
// widths.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int WORD_WIDTH  = 32;
  localparam int OFFSET_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [WORD_WIDTH-1:0]   word_t;
  typedef logic [OFFSET_WIDTH-1:0] offset_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam offset_t OFF_CONTROL = 8'd0;
  localparam offset_t OFF_RELOAD  = 8'd4;
  localparam offset_t OFF_COUNT   = 8'd8;
  localparam offset_t OFF_STATUS  = 8'd12;
  localparam offset_t OFF_CLEAR   = 8'd16;

  localparam int BIT_ENABLE   = 0;
  localparam int BIT_PERIODIC = 1;
  localparam int BIT_IRQ_EN   = 2;
  localparam int BIT_FIRED    = 0;
  localparam int BIT_W1C      = 0;

  typedef struct packed {
    logic [1:0] operation;
    offset_t    reg_offset;
    word_t      write_data;
  } item_t;

  typedef struct packed {
    word_t read_data;
    logic  bus_error;
    logic  irq_pulse;
    logic  irq_pending;
  } result_t;

  // Bus word to counter width: truncate or zero-extend.
  function automatic count_t to_count(input word_t data);
    logic [COUNT_WIDTH+WORD_WIDTH-1:0] wide;
    wide = {{COUNT_WIDTH{1'b0}}, data};
    return wide[COUNT_WIDTH-1:0];
  endfunction

  // Counter value to bus word: low bits, zero-extended when narrower.
  function automatic word_t to_word(input count_t value);
    logic [COUNT_WIDTH+WORD_WIDTH-1:0] wide;
    wide = {{WORD_WIDTH{1'b0}}, value};
    return wide[WORD_WIDTH-1:0];
  endfunction

endpackage

>>> sv/down_counting_timer_regs.sv
// ----------------------------------------------------------------------------
// down_counting_timer_regs : down-counting timer with register access
// Path: an accepted item passes the input register, then the result register;
//   a stall on the output side holds it where it is.
// Throughput: one item per cycle while the output does not stall; the register file updates in one pass.
// Reset: synchronous rst clears control, reload, counter, fired flag and both
//   pipeline valid bits; the block takes items in the cycle after reset.
// ----------------------------------------------------------------------------
module down_counting_timer_regs
  import dct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  offset_t    reg_offset,
  input  word_t      write_data,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output word_t      read_data,
  output logic       bus_error,
  output logic       irq_pulse,
  output logic       irq_pending
);

  // Input register: holds one accepted item until the result slot is free.
  logic    s1_valid;
  item_t   s1_item;

  // Result register: holds the finished result until the sink takes it.
  result_t out_result;
  result_t step_result;

  logic out_free;
  logic step;
  logic in_take;

  // The result slot can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  // Execute the held item exactly when its result can be stored.
  assign step     = s1_valid && out_free;
  // Stall only when the input register is full and cannot move on.
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  dct_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (step_result)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register payload: load on every transfer
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.operation  <= operation;
      s1_item.reg_offset <= reg_offset;
      s1_item.write_data <= write_data;
    end
  end

  // Result register control: fill on step, drop once the sink has taken it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= step_result;
    end
  end

  assign read_data   = out_result.read_data;
  assign bus_error   = out_result.bus_error;
  assign irq_pulse   = out_result.irq_pulse;
  assign irq_pending = out_result.irq_pending;

  // An interrupt pulse always comes with the fired flag set.
  a_pulse_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_pulse |-> irq_pending)
    else $error("irq_pulse without irq_pending");

  // A failed access returns no data and never pulses the interrupt.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_error |-> (read_data == '0) && !irq_pulse)
    else $error("bus error with data or pulse");

  // Input stalls only when the result register is full and held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled without backpressure");

  // A held item stays in the input register while the output is blocked.
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid)
    else $error("held item lost under stall");

endmodule

>>> sv/dct_regfile.sv
// ----------------------------------------------------------------------------
// dct_regfile : timer register file and step logic
// Holds control, reload, counter and fired flag; works out the result of one
// item and commits the new state when step is high.
// ----------------------------------------------------------------------------
module dct_regfile
  import dct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  word_t  control_word;
  word_t  control_word_next;
  count_t reload_value;
  count_t reload_value_next;
  count_t down_count;
  count_t down_count_next;
  logic   fired_flag;
  logic   fired_flag_next;

  count_t count_dec;
  word_t  rd;
  logic   err;
  logic   pulse;

  always_comb begin
    control_word_next = control_word;
    reload_value_next = reload_value;
    down_count_next   = down_count;
    fired_flag_next   = fired_flag;
    rd    = '0;
    err   = 1'b0;
    pulse = 1'b0;
    // saturate at zero: an enabled tick on a zero counter expires at once
    count_dec = (down_count != '0) ? down_count - count_t'(1) : '0;

    case (item.operation)
      OP_TICK: begin
        if (control_word[BIT_ENABLE] && (reload_value != '0)) begin
          down_count_next = count_dec;
          if (count_dec == '0) begin
            fired_flag_next = 1'b1;
            pulse           = control_word[BIT_IRQ_EN];
            if (control_word[BIT_PERIODIC]) begin
              down_count_next = reload_value;
            end else begin
              control_word_next[BIT_ENABLE] = 1'b0;
            end
          end
        end
      end
      OP_READ: begin
        case (item.reg_offset)
          OFF_CONTROL: rd = control_word;
          OFF_RELOAD:  rd = to_word(reload_value);
          OFF_COUNT:   rd = to_word(down_count);
          OFF_STATUS:  rd = {{(WORD_WIDTH-1){1'b0}}, fired_flag};
          default:     err = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (item.reg_offset)
          OFF_CONTROL: begin
            control_word_next = item.write_data;
            // rising enable on an empty counter: load from reload
            if (item.write_data[BIT_ENABLE] && !control_word[BIT_ENABLE] &&
                (down_count == '0)) begin
              down_count_next = reload_value;
            end
          end
          OFF_RELOAD: reload_value_next = to_count(item.write_data);
          OFF_STATUS, OFF_CLEAR: begin
            if (item.write_data[BIT_W1C]) begin
              fired_flag_next = 1'b0;
            end
          end
          default: err = 1'b1;
        endcase
      end
      default: err = 1'b1;
    endcase

    result.read_data   = rd;
    result.bus_error   = err;
    result.irq_pulse   = pulse;
    result.irq_pending = fired_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= '0;
      reload_value <= '0;
      down_count   <= '0;
      fired_flag   <= 1'b0;
    end else if (step) begin
      control_word <= control_word_next;
      reload_value <= reload_value_next;
      down_count   <= down_count_next;
      fired_flag   <= fired_flag_next;
    end
  end

endmodule

>>> sim/timer_checker.sv
// ----------------------------------------------------------------------------
// timer_checker : result predictor and comparator for the down-counting timer
// Follows every accepted transfer on the item channel, computes the response
// the timer owes for it and queues that; each accepted response is matched
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module timer_checker
  import dct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] operation,
  input  offset_t    reg_offset,
  input  word_t      write_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  word_t      read_data,
  input  logic       bus_error,
  input  logic       irq_pulse,
  input  logic       irq_pending,
  output int         fail_count,
  output int         backlog
);

  // Shadow copy of the timer registers.
  word_t   shadow_ctrl;
  count_t  shadow_reload;
  count_t  shadow_count;
  logic    shadow_fired;
  result_t awaited_responses[$];

  initial begin
    fail_count = 0;
    backlog    = 0;
  end

  function automatic result_t advance_timer(input logic [1:0] op, input offset_t off,
                                            input word_t data);
    result_t resp;
    logic    was_on;
    resp = '0;
    case (op)
      OP_TICK: begin
        if (shadow_ctrl[BIT_ENABLE] && shadow_reload != '0) begin
          if (shadow_count != '0) shadow_count = shadow_count - 1'b1;
          if (shadow_count == '0) begin
            shadow_fired   = 1'b1;
            resp.irq_pulse = shadow_ctrl[BIT_IRQ_EN];
            if (shadow_ctrl[BIT_PERIODIC]) shadow_count = shadow_reload;
            else shadow_ctrl[BIT_ENABLE] = 1'b0;
          end
        end
      end
      OP_READ: begin
        case (off)
          OFF_CONTROL: resp.read_data = shadow_ctrl;
          OFF_RELOAD:  resp.read_data = word_t'(shadow_reload);
          OFF_COUNT:   resp.read_data = word_t'(shadow_count);
          OFF_STATUS:  resp.read_data = word_t'(shadow_fired);
          default:     resp.bus_error = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (off)
          OFF_CONTROL: begin
            was_on      = shadow_ctrl[BIT_ENABLE];
            shadow_ctrl = data;
            if (data[BIT_ENABLE] && !was_on && shadow_count == '0)
              shadow_count = shadow_reload;
          end
          OFF_RELOAD: shadow_reload = count_t'(data);
          OFF_STATUS, OFF_CLEAR: begin
            if (data[BIT_W1C]) shadow_fired = 1'b0;
          end
          default: resp.bus_error = 1'b1;
        endcase
      end
      default: resp.bus_error = 1'b1;
    endcase
    resp.irq_pending = shadow_fired;
    return resp;
  endfunction

  task automatic report_field(input string field, input word_t want, input word_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_ctrl   = '0;
      shadow_reload = '0;
      shadow_count  = '0;
      shadow_fired  = 1'b0;
      awaited_responses.delete();
    end else begin
      if (in_valid && !in_stall)
        awaited_responses.push_back(advance_timer(operation, reg_offset, write_data));
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("response with nothing awaited: data %h err %b irq %b pend %b",
                     read_data, bus_error, irq_pulse, irq_pending);
        end else begin
          want = awaited_responses.pop_front();
          if (read_data !== want.read_data)
            report_field("read_data", want.read_data, read_data);
          if (bus_error !== want.bus_error)
            report_field("bus_error", word_t'(want.bus_error), word_t'(bus_error));
          if (irq_pulse !== want.irq_pulse)
            report_field("irq_pulse", word_t'(want.irq_pulse), word_t'(irq_pulse));
          if (irq_pending !== want.irq_pending)
            report_field("irq_pending", word_t'(want.irq_pending), word_t'(irq_pending));
        end
      end
    end
    backlog <= awaited_responses.size();
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : stimulus and verdict for the down-counting timer
// Drives a directed opening (register extremes, forbidden accesses, one-shot
// and periodic expiry, write-1-to-clear, expiry from an already empty counter)
// and then random timer sessions mixed with register noise, with random gaps
// on the item side and random stalls on the response side. Checking lives in
// timer_checker; this module only makes traffic and reports the outcome.
// ----------------------------------------------------------------------------
module tb_top;
  import dct_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int IDLE_LIMIT  = 1000;   // watchdog limit on idle cycles
  localparam int RANDOM_ITEMS = 1500;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [1:0] operation   = OP_TICK;
  offset_t    reg_offset  = OFF_CONTROL;
  word_t      write_data  = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  word_t      read_data;
  logic       bus_error;
  logic       irq_pulse;
  logic       irq_pending;
  int         fail_count;
  int         backlog;

  logic       calm        = 1'b0;   // suppress all gaps and stalls
  int         stall_hold  = 0;
  int         idle_cycles = 0;
  int         items_sent  = 0;

  always #HALF_PERIOD clk = ~clk;

  down_counting_timer_regs dut (.*);
  timer_checker            chk (.*);

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Response side: alternate stretches of stall and flow.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall || calm) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 7);
    end else begin
      n = gap_len();
      out_stall  <= (n != 0);
      stall_hold <= n;
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Present one item and hold it until the transfer completes. Valid is only
  // lowered when a gap precedes the item, so it never gets two updates in a step.
  task automatic send(input logic [1:0] op, input offset_t off, input word_t data);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    reg_offset <= off;
    write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until every awaited response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  function automatic offset_t pick_offset();
    case ($urandom_range(0, 9))
      0:       return OFF_CONTROL;
      1:       return OFF_RELOAD;
      2:       return OFF_COUNT;
      3:       return OFF_STATUS;
      4:       return OFF_CLEAR;
      5, 6:    return offset_t'($urandom_range(0, 255));
      default: return offset_t'($urandom_range(0, 4) * 4);
    endcase
  endfunction

  // Short periods so that the counter actually expires; now and then a big one.
  function automatic word_t pick_reload();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return '0;
    if (roll < 3) return $urandom;
    return $urandom_range(1, 12);
  endfunction

  // One timer session: programme, start, tick it through, peek and acknowledge.
  task automatic run_session();
    word_t ctrl;
    int    ticks;
    if ($urandom_range(0, 2) == 0) send(OP_WRITE, OFF_CONTROL, $urandom & ~word_t'(1));
    send(OP_WRITE, OFF_RELOAD, pick_reload());
    ctrl = $urandom;
    ctrl[BIT_ENABLE] = 1'b1;
    send(OP_WRITE, OFF_CONTROL, ctrl);
    ticks = $urandom_range(1, 30);
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0:       send(OP_READ, OFF_COUNT, $urandom);
        1:       send(OP_READ, OFF_STATUS, $urandom);
        2:       send(OP_WRITE, ($urandom_range(0, 1) != 0) ? OFF_STATUS : OFF_CLEAR,
                      $urandom);
        3:       send(OP_READ, OFF_CONTROL, $urandom);
        default: send(OP_TICK, pick_offset(), $urandom);
      endcase
    end
    send(OP_READ, OFF_STATUS, $urandom);
  endtask

  initial begin
    bit pressure_done;
    pressure_done = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: everything reads zero after reset.
    send(OP_READ,  OFF_CONTROL, '1);
    send(OP_READ,  OFF_RELOAD,  '0);
    send(OP_READ,  OFF_COUNT,   '0);
    send(OP_READ,  OFF_STATUS,  '0);
    // Forbidden accesses: read of clear, write of count, unknown offsets.
    send(OP_READ,  OFF_CLEAR,   '0);
    send(OP_READ,  8'hFF,       '0);
    send(OP_WRITE, OFF_COUNT,   '1);
    send(OP_WRITE, 8'd20,       '1);
    // Reload extremes, then a short periodic run with irq and every control bit.
    send(OP_WRITE, OFF_RELOAD,  '1);
    send(OP_READ,  OFF_RELOAD,  '0);
    send(OP_WRITE, OFF_RELOAD,  32'd3);
    send(OP_WRITE, OFF_CONTROL, '1);
    send(OP_READ,  OFF_CONTROL, '0);
    repeat (4) send(OP_TICK, '0, '0);
    // Write-1-to-clear: bit 0 clear leaves fired, bit 0 set clears it.
    send(OP_WRITE, OFF_STATUS,  32'hFFFF_FFFE);
    send(OP_WRITE, OFF_CLEAR,   32'd1);
    // One-shot with irq: expiry drops enable, later ticks do nothing.
    send(OP_WRITE, OFF_CONTROL, 32'd5);
    repeat (4) send(OP_TICK, 8'hFF, '1);
    send(OP_READ,  OFF_COUNT,   '0);
    // Counter already empty: enable with zero reload, then set reload and tick.
    send(OP_WRITE, OFF_RELOAD,  '0);
    send(OP_WRITE, OFF_CONTROL, 32'd1);
    send(OP_TICK,  '0,          '0);
    send(OP_WRITE, OFF_RELOAD,  32'd5);
    send(OP_TICK,  '0,          '0);
    send(OP_WRITE, OFF_STATUS,  32'd1);

    // Random part: mostly timer sessions, the rest register noise.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) calm <= ~calm;
      if (!pressure_done && items_sent > RANDOM_ITEMS / 2) begin
        drain();
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_session();
        6, 7: repeat ($urandom_range(1, 8))
                send(($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE, pick_offset(),
                     $urandom);
        8: repeat ($urandom_range(1, 6))
             send(2'($urandom_range(0, 2)), pick_offset(), $urandom);
        default: repeat ($urandom_range(1, 10)) send(OP_TICK, pick_offset(), $urandom);
      endcase
    end

    // Let the last responses arrive, then a few spare cycles for strays.
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dct_pkg.sv
sv/dct_regfile.sv
sv/down_counting_timer_regs.sv
sim/timer_checker.sv
sim/tb_top.sv
